@@ rtl/depth_temporal_filter_macros.svh @@
// assertion macros for the depth temporal filter
`ifndef DEPTH_TEMPORAL_FILTER_MACROS_SVH
`define DEPTH_TEMPORAL_FILTER_MACROS_SVH

// property checked on the rising clock edge, off while in reset
`define DTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DTF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dtf_pkg.sv @@
// shared types, constants and functions of the depth temporal filter
package dtf_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int DEPTH_W    = 16;
  localparam int HIST_W     = 8;
  localparam int ALPHA_W    = 9;
  localparam int GAP_W      = 17;
  localparam int LEVEL_W    = 4;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ALPHA_W-1:0] Q8_ONE = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST   = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd102;
  localparam logic [GAP_W-1:0]   GAP_RST     = 17'd20;
  localparam logic [LEVEL_W-1:0] PERSIST_RST = 4'd3;

  localparam logic [LEVEL_W-1:0] LVL_ALL8     = 4'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO_OF3  = 4'd2;
  localparam logic [LEVEL_W-1:0] LVL_TWO_OF4  = 4'd3;
  localparam logic [LEVEL_W-1:0] LVL_TWO_OF8  = 4'd4;
  localparam logic [LEVEL_W-1:0] LVL_ANY_OF2  = 4'd5;
  localparam logic [LEVEL_W-1:0] LVL_ANY_OF5  = 4'd6;
  localparam logic [LEVEL_W-1:0] LVL_ANY_OF8  = 4'd7;
  localparam logic [LEVEL_W-1:0] LVL_ALWAYS   = 4'd8;

  typedef struct packed {
    logic [HIST_W-1:0]  hist;
    logic [DEPTH_W-1:0] depth;
  } word_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [GAP_W-1:0]   blend_gap;
    logic [LEVEL_W-1:0] level;
  } cfg_t;

  function automatic logic [3:0] popcnt8(input logic [HIST_W-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < HIST_W; i++) begin
      n = n + {3'b0, v[i]};
    end
    return n;
  endfunction

  function automatic logic hole_fill_ok(input logic [HIST_W-1:0] hist,
                                        input logic [LEVEL_W-1:0] level);
    logic ok;
    case (level)
      LVL_ALL8:    ok = (hist == 8'hFF);
      LVL_TWO_OF3: ok = (popcnt8(hist & 8'h07) >= 4'd2);
      LVL_TWO_OF4: ok = (popcnt8(hist & 8'h0F) >= 4'd2);
      LVL_TWO_OF8: ok = (popcnt8(hist) >= 4'd2);
      LVL_ANY_OF2: ok = ((hist & 8'h03) != 8'h00);
      LVL_ANY_OF5: ok = ((hist & 8'h1F) != 8'h00);
      LVL_ANY_OF8: ok = (hist != 8'h00);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/dtf_calc.sv @@
// per-pixel blend, hole fill and history update
module dtf_calc (
  input  dtf_pkg::cfg_t                cfg_i,
  input  dtf_pkg::word_t               word_i,
  input  logic [dtf_pkg::DEPTH_W-1:0]  cur_i,
  output logic [dtf_pkg::DEPTH_W-1:0]  result_o,
  output dtf_pkg::word_t               word_o
);

  logic                               cur_valid;
  logic [dtf_pkg::DEPTH_W-1:0]        prev;
  logic [dtf_pkg::ALPHA_W-1:0]        a_sat;
  logic signed [dtf_pkg::DEPTH_W:0]   diff;
  logic signed [dtf_pkg::DEPTH_W:0]   diff_neg;
  logic [dtf_pkg::DEPTH_W-1:0]        gap;
  logic signed [26:0]                 prod;
  logic signed [26:0]                 acc;
  logic [dtf_pkg::DEPTH_W-1:0]        blended;
  logic                               blend_en;
  logic                               fill;

  assign cur_valid = (cur_i != '0);
  assign prev      = word_i.depth;
  assign a_sat     = (cfg_i.alpha > dtf_pkg::Q8_ONE) ? dtf_pkg::Q8_ONE : cfg_i.alpha;

  assign diff     = signed'({1'b0, cur_i}) - signed'({1'b0, prev});
  assign diff_neg = -diff;
  assign gap      = diff[dtf_pkg::DEPTH_W] ? diff_neg[dtf_pkg::DEPTH_W-1:0]
                                            : diff[dtf_pkg::DEPTH_W-1:0];

  // a*cur + (256-a)*prev == 256*prev + a*(cur-prev)
  assign prod    = signed'({1'b0, a_sat}) * diff;
  assign acc     = signed'({3'b0, prev, 8'b0}) + prod;
  assign blended = acc[23:8];

  assign blend_en = (prev != '0) && ({1'b0, gap} < cfg_i.blend_gap);

  always_comb begin
    if (cfg_i.level == dtf_pkg::LVL_ALWAYS) begin
      fill = (prev != '0);
    end else begin
      fill = dtf_pkg::hole_fill_ok(word_i.hist, cfg_i.level);
    end
  end

  always_comb begin
    if (cur_valid) begin
      result_o = blend_en ? blended : cur_i;
    end else begin
      result_o = fill ? prev : '0;
    end
    word_o.hist  = {word_i.hist[dtf_pkg::HIST_W-2:0], cur_valid};
    word_o.depth = cur_valid ? result_o : prev;
  end

endmodule

@@ rtl/depth_temporal_filter.sv @@
// depth temporal filter top level: per-pixel state memory and read-modify-write pipeline
// an accepted word is read, modified in the modify stage and held in the output register
// throughput: one word per cycle unless output stalls; one read and one write port on
// state memory; read at accept, written back from the modify stage, last write forwarded
// after reset all 1048576 state memory words are cleared, input not ready meanwhile
// config registers reset to alpha 102, blend gap 20, persistence level 3
module depth_temporal_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dtf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtf_pkg::ADDR_W-1:0]    pixel_addr_i,
  input  logic [dtf_pkg::DEPTH_W-1:0]   depth_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtf_pkg::DEPTH_W-1:0]   depth_out_o
);

  `include "depth_temporal_filter_macros.svh"

  dtf_pkg::cfg_t                 cfg_q;
  dtf_pkg::word_t                mem [dtf_pkg::MAX_PIXELS];
  dtf_pkg::word_t                rd_q;
  dtf_pkg::word_t                cur_word;
  dtf_pkg::word_t                new_word;
  dtf_pkg::word_t                wb_data_q;
  logic [dtf_pkg::ADDR_W-1:0]    wb_addr_q;
  logic                          wb_valid_q;
  logic                          clr_busy_q;
  logic [dtf_pkg::ADDR_W-1:0]    clr_addr_q;
  logic                          s1_valid_q;
  logic [dtf_pkg::ADDR_W-1:0]    s1_addr_q;
  logic [dtf_pkg::DEPTH_W-1:0]   s1_depth_q;
  logic                          out_valid_q;
  logic [dtf_pkg::DEPTH_W-1:0]   depth_out_q;
  logic [dtf_pkg::DEPTH_W-1:0]   result;
  logic                          in_fire;
  logic                          s1_adv;
  logic                          mem_we;
  logic [dtf_pkg::ADDR_W-1:0]    mem_waddr;
  dtf_pkg::word_t                mem_wdata;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= dtf_pkg::ALPHA_RST;
      cfg_q.blend_gap <= dtf_pkg::GAP_RST;
      cfg_q.level     <= dtf_pkg::PERSIST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtf_pkg::CFG_ALPHA:     cfg_q.alpha     <= cfg_data_i[dtf_pkg::ALPHA_W-1:0];
        dtf_pkg::CFG_BLEND_GAP: cfg_q.blend_gap <= cfg_data_i[dtf_pkg::GAP_W-1:0];
        dtf_pkg::CFG_PERSIST:   cfg_q.level     <= cfg_data_i[dtf_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // state memory
  assign mem_we    = clr_busy_q || s1_adv;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? dtf_pkg::word_t'('0) : new_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= mem[pixel_addr_i];
    end
  end

  // last write, forwarded to a read issued at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (clr_busy_q) begin
      wb_valid_q <= 1'b0;
    end else if (s1_adv) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wb_addr_q <= s1_addr_q;
      wb_data_q <= new_word;
    end
  end

  assign cur_word = (wb_valid_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : rd_q;

  // modify stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q  <= pixel_addr_i;
      s1_depth_q <= depth_in_i;
    end
  end

  dtf_calc u_calc (
    .cfg_i    (cfg_q),
    .word_i   (cur_word),
    .cur_i    (s1_depth_q),
    .result_o (result),
    .word_o   (new_word)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      depth_out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign depth_out_o = depth_out_q;

  `DTF_ASSERT_IMPL(a_no_accept_in_clear, clr_busy_q, !in_ready_o && !s1_valid_q, "accept during memory clear")
  `DTF_ASSERT_NEXT(a_s1_hold, s1_valid_q && out_valid_q && !out_ready_i, s1_valid_q && $stable(s1_addr_q) && $stable(s1_depth_q), "modify stage lost word under stall")
  `DTF_ASSERT_IMPL(a_clear_end, $fell(clr_busy_q), $past(clr_addr_q) == '1, "memory clear ended early")
  `DTF_ASSERT_NEXT(a_wb_tracks, s1_adv, wb_valid_q && wb_addr_q == $past(s1_addr_q), "forward register missed a write")

endmodule
